// ===== hdl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// Package for the SHA-256 byte stream hasher.
// Holds the round constants, the initial hash values and the SHA-256 mixing functions.
package sha256_pkg;

    localparam logic [31:0] c_round_k [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] c_init_h [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] c_pad_byte = 8'h80;
    localparam logic [5:0] c_len_pos  = 6'd56;
    localparam logic       c_op_absorb = 1'b0;
    localparam logic       c_op_finish = 1'b1;

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        return f_rotr(x, 7) ^ f_rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        return f_rotr(x, 17) ^ f_rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        return f_rotr(x, 2) ^ f_rotr(x, 13) ^ f_rotr(x, 22);
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        return f_rotr(x, 6) ^ f_rotr(x, 11) ^ f_rotr(x, 25);
    endfunction

endpackage

// ===== hdl/sha256_byte_stream_hasher_top.sv =====
`timescale 1ns / 1ps
// Top level of the SHA-256 byte stream hasher: buffer memory, compression rounds, digest output.
// Depends on sha256_pkg.
//
// Bytes go into a 64-entry byte memory, one byte per cycle, while the hasher is idle and ready.
// The 64th byte of a block starts compression: a load step reads the bytes one per cycle into the
// schedule window, then 64 rounds run one per cycle, then an add step adds into the hash words, so
// input is held off until the block is compressed. A finish word pads the buffer one byte per
// cycle up to the end of the block, compresses once, or twice with a second padding pass over the
// whole block when 56 or more bytes are buffered, and then offers the eight digest words in order;
// the next word is taken once the last digest word leaves. The buffer memory needs no clearing
// after reset.
module sha256_byte_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_OUT
    } t_state;

    t_state      r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_total;
    logic        r_final;
    logic        r_len_done;
    logic [5:0]  r_pad_pos;
    logic [6:0]  r_cnt;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [2:0]  r_oidx;

    logic [7:0]  r_mem [64];
    logic [7:0]  r_rdata;
    logic        r_we;
    logic [5:0]  r_waddr;
    logic [7:0]  r_wdata;
    logic [5:0]  n_raddr;

    logic        in_fire;
    logic        out_fire;
    logic [31:0] n_w;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [5:0]  n_fill;
    logic [5:0]  load_pos;
    logic [7:0]  pad_byte;

    assign o_ready  = (r_state == S_IDLE);
    assign in_fire  = i_valid && o_ready;
    assign o_valid  = (r_state == S_OUT);
    assign out_fire = o_valid && i_ready;
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);
    assign n_fill = r_fill + 6'd1;
    assign load_pos = r_cnt[5:0] - 6'd1;

    // The byte read at count k arrives at count k + 1.
    always_comb begin
        n_raddr = 6'd0;
        if (r_state == S_LOAD) begin
            n_raddr = r_cnt[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_waddr] <= r_wdata;
        end
        r_rdata <= r_mem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we <= 1'b0;
        end else begin
            r_we <= (in_fire && i_op == c_op_absorb) || (r_state == S_PAD);
        end
        r_waddr <= (r_state == S_PAD) ? r_pad_pos : r_fill;
        r_wdata <= (r_state == S_PAD) ? pad_byte : i_data_byte;
    end

    always_comb begin
        if (r_pad_pos >= c_len_pos && r_len_done) begin
            pad_byte = r_total[8 * (7 - (r_pad_pos - c_len_pos)) +: 8];
        end else if (r_pad_pos == r_fill && !r_final) begin
            pad_byte = c_pad_byte;
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign n_w = r_w[0] + f_ssig0(r_w[1]) + r_w[9] + f_ssig1(r_w[14]);
    assign t1  = r_v[7] + f_bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
               + c_round_k[r_cnt[5:0]] + r_w[0];
    assign t2  = f_bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_final <= 1'b0;
            r_len_done <= 1'b0;
            r_oidx  <= '0;
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= c_init_h[j];
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_op == c_op_absorb) begin
                            r_fill  <= n_fill;
                            if (n_fill == 6'd0) begin
                                r_final <= 1'b0;
                                r_cnt   <= '0;
                                r_state <= S_LOAD;
                            end
                        end else begin
                            r_total    <= r_bits + {55'd0, r_fill, 3'd0};
                            r_final    <= 1'b0;
                            r_len_done <= (r_fill < c_len_pos);
                            r_pad_pos  <= r_fill;
                            r_state    <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pad_pos <= r_pad_pos + 6'd1;
                    if (r_pad_pos == 6'd63) begin
                        // After the first pad block of a long tail, the next pass is the length block.
                        if (!r_len_done) begin
                            r_final <= 1'b1;
                        end
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_cnt != 7'd0) begin
                        r_w[load_pos[5:2]] <= {r_w[load_pos[5:2]][23:0], r_rdata};
                    end
                    if (r_cnt == 7'd64) begin
                        r_cnt   <= '0;
                        for (int j = 0; j < 8; j++) begin
                            r_v[j] <= r_h[j];
                        end
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_ROUND: begin
                    for (int j = 0; j < 15; j++) begin
                        r_w[j] <= r_w[j + 1];
                    end
                    r_w[15] <= n_w;
                    for (int j = 1; j < 8; j++) begin
                        if (j != 4) begin
                            r_v[j] <= r_v[j - 1];
                        end
                    end
                    r_v[4] <= r_v[3] + t1;
                    r_v[0] <= t1 + t2;
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int j = 0; j < 8; j++) begin
                        r_h[j] <= r_h[j] + r_v[j];
                    end
                    if (r_len_done) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else if (r_final) begin
                        r_len_done <= 1'b1;
                        r_pad_pos  <= '0;
                        r_state    <= S_PAD;
                    end else begin
                        r_bits  <= r_bits + 64'd512;
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (out_fire) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_fill  <= '0;
                            r_bits  <= '0;
                            r_final <= 1'b0;
                            r_len_done <= 1'b0;
                            for (int j = 0; j < 8; j++) begin
                                r_h[j] <= c_init_h[j];
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready during digest output");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_word) |-> (o_word_index == 3'd7)) else $error("last flag misplaced");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_word_index)))
        else $error("digest word dropped");
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_last_word) |=> (r_fill == 6'd0 && r_bits == 64'd0))
        else $error("state not restored after digest");
`endif

endmodule
